// ===== hdl/rau_pkg.sv =====
`timescale 1ns / 1ps
package rau_pkg;
	localparam int DEF_WIDTH = 32;
	localparam int MAG_W = 64;
	localparam logic [2:0] KIND_LOAD = 3'd0;
	localparam logic [2:0] KIND_ADD  = 3'd1;
	localparam logic [2:0] KIND_SUB  = 3'd2;
	localparam logic [2:0] KIND_MUL  = 3'd3;
	localparam logic [2:0] KIND_DIV  = 3'd4;
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZDEN = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;
	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] operand_num;
		logic signed [31:0] operand_den;
	} rau_in_t;
	typedef struct packed {
		logic signed [31:0] result_num;
		logic [30:0]        result_den;
		logic [1:0]         status;
	} rau_out_t;
endpackage

// ===== hdl/rau_in_if.sv =====
`timescale 1ns / 1ps
interface rau_in_if import rau_pkg::*; ();
	logic    valid;
	logic    ready;
	rau_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/rau_out_if.sv =====
`timescale 1ns / 1ps
interface rau_out_if import rau_pkg::*; ();
	logic     valid;
	logic     ready;
	rau_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Payload                            | Handshake
// in      | sink      | kind, operand_num, operand_den     | valid / ready
// out     | source    | result_num, result_den, status     | valid / ready
//
// Setup and products come first. Each Euclidean modulo step and each of the two
// reducing divisions run on one shared 64-bit divider that yields one quotient bit
// per cycle. The number of gcd steps sets the total time.
// arst_n clears the accumulator to 0/1 and the sequencer to idle. The input is not
// ready while a transaction is in work or its result waits; a stalled output holds it.
module rational_arithmetic_unit import rau_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH
) (
	input logic clk,
	input logic arst_n,
	rau_in_if.sink in_ch,
	rau_out_if.source out_ch
);
	localparam int EW = (WIDTH > 32) ? 32 : WIDTH;
	localparam logic [MAG_W-1:0] LIM = MAG_W'(1) << (EW - 1);
	localparam int CW = 7;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_P1   = 4'd1;
	localparam logic [3:0] S_P2   = 4'd2;
	localparam logic [3:0] S_P3   = 4'd3;
	localparam logic [3:0] S_SUM  = 4'd4;
	localparam logic [3:0] S_GCD  = 4'd5;
	localparam logic [3:0] S_DIV  = 4'd6;
	localparam logic [3:0] S_DN   = 4'd7;
	localparam logic [3:0] S_DD   = 4'd8;
	localparam logic [3:0] S_CHK  = 4'd9;
	localparam logic [3:0] S_OUT  = 4'd10;

	logic [3:0] state_q;
	logic [31:0] acc_num_q, acc_den_q;
	logic [2:0] kind_q;
	logic on_neg_q, od_neg_q, an_neg_q;
	logic [31:0] on_mag_q, od_mag_q, an_mag_q, ad_mag_q;
	logic [MAG_W-1:0] p_q, q_q, n_mag_q, d_mag_q, ga_q, gb_q;
	logic p_neg_q, q_neg_q, n_neg_q, d_neg_q;
	logic [MAG_W-1:0] dv_num_q, dv_den_q, dv_rem_q, dv_quo_q;
	logic [CW-1:0] cnt_q;
	logic [1:0] dv_mode_q;
	logic [MAG_W-1:0] nm_q;
	rau_out_t res_q;
	logic out_v_q;

	// Shared 32x32 multiplier operands.
	logic [31:0] ma, mb;
	logic [MAG_W-1:0] mp;
	// Shared divider step.
	logic [MAG_W:0] rem_sh;
	logic [MAG_W:0] rem_sub;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	always_comb begin
		case (state_q)
			S_P1: begin ma = an_mag_q; mb = (kind_q == KIND_MUL) ? on_mag_q : od_mag_q; end
			S_P2: begin ma = ad_mag_q; mb = (kind_q == KIND_DIV) ? on_mag_q : od_mag_q; end
			default: begin ma = ad_mag_q; mb = on_mag_q; end
		endcase
		mp = MAG_W'(ma) * MAG_W'(mb);
		rem_sh = {dv_rem_q, dv_num_q[MAG_W-1]};
		rem_sub = rem_sh - {1'b0, dv_den_q};
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = out_v_q;
	assign out_ch.data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			acc_num_q <= '0;
			acc_den_q <= 32'd1;
			out_v_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						kind_q <= in_ch.data.kind;
						on_neg_q <= in_ch.data.operand_num[31];
						od_neg_q <= in_ch.data.operand_den[31];
						on_mag_q <= mag32(in_ch.data.operand_num);
						od_mag_q <= mag32(in_ch.data.operand_den);
						an_neg_q <= acc_num_q[31];
						an_mag_q <= mag32(acc_num_q);
						ad_mag_q <= mag32(acc_den_q);
						if (in_ch.data.kind > KIND_DIV) begin
							res_q <= '{acc_num_q, acc_den_q[30:0], ST_OK};
							state_q <= S_OUT;
							out_v_q <= 1'b1;
						end else begin
							state_q <= S_P1;
						end
					end
				end
				S_P1: begin
					// First product: numerator term (or whole numerator).
					case (kind_q)
						KIND_LOAD: begin
							p_q <= MAG_W'(on_mag_q);
							p_neg_q <= on_neg_q && on_mag_q != 0;
						end
						KIND_MUL: begin
							p_q <= mp;
							p_neg_q <= (an_neg_q != on_neg_q) && mp != 0;
						end
						default: begin
							p_q <= mp;
							p_neg_q <= (an_neg_q != od_neg_q) && mp != 0;
						end
					endcase
					state_q <= S_P2;
				end
				S_P2: begin
					// Denominator product.
					if (kind_q == KIND_LOAD) begin
						d_mag_q <= MAG_W'(od_mag_q);
						d_neg_q <= od_neg_q;
					end else begin
						d_mag_q <= mp;
						d_neg_q <= ((kind_q == KIND_DIV) ? on_neg_q : od_neg_q) && mp != 0;
					end
					state_q <= S_P3;
				end
				S_P3: begin
					// Cross term ad*on for add and subtract.
					q_q <= mp;
					q_neg_q <= ((kind_q == KIND_SUB) ? !on_neg_q : on_neg_q) && mp != 0;
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (kind_q == KIND_ADD || kind_q == KIND_SUB) begin
						if (p_neg_q == q_neg_q) begin
							n_mag_q <= p_q + q_q;
							n_neg_q <= p_neg_q && (p_q + q_q) != 0;
						end else if (p_q >= q_q) begin
							n_mag_q <= p_q - q_q;
							n_neg_q <= p_neg_q && p_q != q_q;
						end else begin
							n_mag_q <= q_q - p_q;
							n_neg_q <= q_neg_q;
						end
					end else begin
						n_mag_q <= p_q;
						n_neg_q <= p_neg_q;
					end
					if (d_mag_q == 0) begin
						res_q <= '{acc_num_q, acc_den_q[30:0], ST_ZDEN};
						out_v_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						ga_q <= (kind_q == KIND_ADD || kind_q == KIND_SUB) ? '0 : p_q;
						gb_q <= d_mag_q;
						state_q <= S_GCD;
					end
				end
				S_GCD: begin
					// gcd(a,b): on first entry for add/sub, ga_q is loaded here.
					if (kind_q == KIND_ADD || kind_q == KIND_SUB) begin
						kind_q <= KIND_LOAD;
						ga_q <= n_mag_q;
					end else if (gb_q == 0) begin
						dv_num_q <= n_mag_q;
						dv_den_q <= ga_q;
						dv_rem_q <= '0;
						cnt_q <= '0;
						dv_mode_q <= 2'd1;
						state_q <= S_DIV;
					end else begin
						dv_num_q <= ga_q;
						dv_den_q <= gb_q;
						dv_rem_q <= '0;
						cnt_q <= '0;
						dv_mode_q <= 2'd0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					// Restoring division, one quotient bit per cycle.
					dv_num_q <= dv_num_q << 1;
					if (!rem_sub[MAG_W]) begin
						dv_rem_q <= rem_sub[MAG_W-1:0];
						dv_quo_q <= {dv_quo_q[MAG_W-2:0], 1'b1};
					end else begin
						dv_rem_q <= rem_sh[MAG_W-1:0];
						dv_quo_q <= {dv_quo_q[MAG_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(MAG_W - 1)) begin
						case (dv_mode_q)
							2'd0: state_q <= S_DN;
							2'd1: state_q <= S_DN;
							default: state_q <= S_DD;
						endcase
					end
				end
				S_DN: begin
					if (dv_mode_q == 2'd0) begin
						ga_q <= gb_q;
						gb_q <= dv_rem_q;
						state_q <= S_GCD;
					end else begin
						nm_q <= dv_quo_q;
						dv_num_q <= d_mag_q;
						dv_rem_q <= '0;
						cnt_q <= '0;
						dv_mode_q <= 2'd2;
						state_q <= S_DIV;
					end
				end
				S_DD: begin
					d_mag_q <= dv_quo_q;
					n_neg_q <= (n_neg_q != d_neg_q) && nm_q != 0;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (d_mag_q > LIM - 1 || (n_neg_q ? nm_q > LIM : nm_q > LIM - 1)) begin
						res_q <= '{acc_num_q, acc_den_q[30:0], ST_OVF};
					end else begin
						acc_num_q <= n_neg_q ? 32'(MAG_W'(0) - nm_q) : nm_q[31:0];
						acc_den_q <= d_mag_q[31:0];
						res_q <= '{(n_neg_q ? 32'(MAG_W'(0) - nm_q) : nm_q[31:0]),
							d_mag_q[30:0], ST_OK};
					end
					out_v_q <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ch.ready) begin
						out_v_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A result is offered only while the sequencer sits in its output state.
	a_valid_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> state_q == S_OUT) else $error("result valid outside output state");
	// The accumulator never holds a zero denominator.
	a_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		acc_den_q != 0) else $error("zero denominator stored");
	// A taken result returns the sequencer to idle.
	a_ret_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready |=> state_q == S_IDLE) else $error("no return to idle");
endmodule

// ===== tb/tb_rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit;
	import rau_pkg::*;

	// Kinds that the block must treat as no operation.
	localparam logic [2:0] KIND_NOP5 = 3'd5;
	localparam logic [2:0] KIND_NOP6 = 3'd6;
	localparam logic [2:0] KIND_NOP7 = 3'd7;
	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
	localparam int RANDOM_ITEMS = 430;
	localparam longint CYCLE_LIMIT = 64'd12_000_000;

	// One row of the directed table. When checked_here is set, the row's own
	// expected result is used instead of the predictor's.
	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] num;
		logic [31:0] den;
		logic        checked_here;
		rau_out_t    want;
	} row_t;

	localparam int N_ROWS = 24;
	localparam row_t DIRECTED [N_ROWS] = '{
		'{KIND_ADD,  32'sd0,   32'sd1,   1'b1, '{32'sd0, 31'd1, ST_OK}},
		'{KIND_LOAD, 32'sd5,   32'sd0,   1'b1, '{32'sd0, 31'd1, ST_ZDEN}},
		'{KIND_LOAD, INT_MIN,  32'sd1,   1'b1, '{INT_MIN, 31'd1, ST_OK}},
		'{KIND_LOAD, 32'sd1,   INT_MIN,  1'b1, '{INT_MIN, 31'd1, ST_OVF}},
		'{KIND_SUB,  32'sd1,   32'sd1,   1'b1, '{INT_MIN, 31'd1, ST_OVF}},
		'{KIND_LOAD, 32'sd7,   -32'sd14, 1'b1, '{-32'sd1, 31'd2, ST_OK}},
		'{KIND_NOP5, 32'sd9,   32'sd9,   1'b1, '{-32'sd1, 31'd2, ST_OK}},
		'{KIND_ADD,  32'sd3,   32'sd4,   1'b0, '0},
		'{KIND_SUB,  -32'sd5,  32'sd6,   1'b0, '0},
		'{KIND_MUL,  32'sd2,   -32'sd3,  1'b0, '0},
		'{KIND_DIV,  32'sd4,   32'sd5,   1'b0, '0},
		'{KIND_DIV,  32'sd0,   32'sd3,   1'b0, '0},
		'{KIND_LOAD, 32'sd0,   -32'sd9,  1'b1, '{32'sd0, 31'd1, ST_OK}},
		'{KIND_DIV,  32'sd0,   32'sd1,   1'b1, '{32'sd0, 31'd1, ST_ZDEN}},
		'{KIND_LOAD, INT_MAX,  -32'sd1,  1'b1, '{-INT_MAX, 31'd1, ST_OK}},
		'{KIND_MUL,  32'sd2,   32'sd1,   1'b0, '0},
		'{KIND_NOP6, INT_MIN,  INT_MIN,  1'b0, '0},
		'{KIND_LOAD, -32'sd1,  -32'sd1,  1'b1, '{32'sd1, 31'd1, ST_OK}},
		'{KIND_LOAD, INT_MAX,  INT_MAX,  1'b1, '{32'sd1, 31'd1, ST_OK}},
		'{KIND_LOAD, INT_MIN,  INT_MIN,  1'b1, '{32'sd1, 31'd1, ST_OK}},
		'{KIND_LOAD, 32'sd2147483646, INT_MAX, 1'b0, '0},
		'{KIND_NOP7, -32'sd1,  32'sd0,   1'b0, '0},
		'{KIND_LOAD, INT_MIN,  -32'sd1,  1'b0, '0},
		'{KIND_LOAD, 32'sd0,   INT_MIN,  1'b1, '{32'sd0, 31'd1, ST_OK}}
	};

	typedef struct {
		bit              neg;
		longint unsigned mag;
	} smag_t;

	logic clk;
	logic arst_n;
	rau_in_if  in_ch();
	rau_out_if out_ch();

	rational_arithmetic_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// The predictor's copy of the accumulator.
	logic signed [31:0] frac_num;
	logic signed [31:0] frac_den;

	// Results still owed by the block, oldest first.
	rau_out_t pending_results[$];

	int  send_idle_pct;
	int  recv_stall_pct;
	int  errors;
	int  results_seen;
	int  zden_seen;
	int  ovf_seen;
	int  ok_seen;
	longint cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic smag_t to_smag(logic [31:0] v);
		smag_t r;
		r.neg = v[31];
		r.mag = v[31] ? 64'(32'(~v + 32'd1)) : 64'(v);
		return r;
	endfunction

	function automatic smag_t smag_mul(smag_t a, smag_t b);
		smag_t r;
		r.mag = a.mag * b.mag;
		r.neg = (a.neg != b.neg) && r.mag != 0;
		return r;
	endfunction

	function automatic smag_t smag_add(smag_t a, smag_t b);
		smag_t r;
		if (a.neg == b.neg) begin
			r.mag = a.mag + b.mag;
			r.neg = a.neg;
		end else if (a.mag >= b.mag) begin
			r.mag = a.mag - b.mag;
			r.neg = a.neg;
		end else begin
			r.mag = b.mag - a.mag;
			r.neg = b.neg;
		end
		if (r.mag == 0)
			r.neg = 1'b0;
		return r;
	endfunction

	// Applies one operation to the accumulator copy and returns what the
	// block should report: the new or the unchanged fraction and a status.
	function automatic rau_out_t apply_fraction_op(logic [2:0] kind,
			logic [31:0] op_num, logic [31:0] op_den);
		smag_t on, od, an, ad, n, d;
		longint unsigned g, a, b, t, nm, dm;
		longint unsigned lim;
		logic [1:0] st;
		rau_out_t r;
		on = to_smag(op_num);
		od = to_smag(op_den);
		an = to_smag(frac_num);
		ad = to_smag(frac_den);
		lim = 64'd1 << 31;
		st = ST_OK;
		n = '{1'b0, 0};
		d = '{1'b0, 1};
		case (kind)
			KIND_LOAD: begin
				n = on;
				d = od;
			end
			KIND_ADD, KIND_SUB: begin
				if (kind == KIND_SUB)
					on.neg = !on.neg && on.mag != 0;
				n = smag_add(smag_mul(an, od), smag_mul(ad, on));
				d = smag_mul(ad, od);
			end
			KIND_MUL: begin
				n = smag_mul(an, on);
				d = smag_mul(ad, od);
			end
			KIND_DIV: begin
				n = smag_mul(an, od);
				d = smag_mul(ad, on);
			end
			default: st = ST_OK;
		endcase
		if (kind <= KIND_DIV) begin
			if (d.mag == 0) begin
				st = ST_ZDEN;
			end else begin
				a = n.mag;
				b = d.mag;
				while (b != 0) begin
					t = a % b;
					a = b;
					b = t;
				end
				g = a;
				nm = n.mag / g;
				dm = d.mag / g;
				n.neg = (n.neg != d.neg) && nm != 0;
				if (dm > lim - 1 || (n.neg ? nm > lim : nm > lim - 1)) begin
					st = ST_OVF;
				end else begin
					frac_num = n.neg ? 32'(64'd0 - nm) : 32'(nm);
					frac_den = 32'(dm);
				end
			end
		end
		r.result_num = frac_num;
		r.result_den = frac_den[30:0];
		r.status = st;
		return r;
	endfunction

	// Drives one transaction and holds it until the block takes it. The
	// expectation is queued at the edge of acceptance.
	task automatic send_op(logic [2:0] kind, logic [31:0] num, logic [31:0] den,
			bit checked_here, rau_out_t want);
		rau_out_t predicted;
		in_ch.valid <= 1'b1;
		in_ch.data <= '{kind, num, den};
		do @(posedge clk); while (!in_ch.ready);
		predicted = apply_fraction_op(kind, num, den);
		pending_results.push_back(checked_here ? want : predicted);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// Hold the sender off until every result owed has come back.
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] random_operand(bit allow_zero);
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0, 1: v = $urandom;
			2: v = $urandom >> $urandom_range(0, 31);
			3: v = allow_zero ? 32'd0 : 32'd1;
			default: v = 32'($urandom_range(1, 40));
		endcase
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	// Result checking and receiver stalls.
	always @(posedge clk) begin
		rau_out_t want;
		if (out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: num %0d den %0d status %0d",
					out_ch.data.result_num, out_ch.data.result_den, out_ch.data.status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				results_seen++;
				case (want.status)
					ST_ZDEN: zden_seen++;
					ST_OVF:  ovf_seen++;
					default: ok_seen++;
				endcase
				if (out_ch.data.result_num !== want.result_num) begin
					$error("result_num: expected %0d, actual %0d",
						want.result_num, out_ch.data.result_num);
					errors++;
				end
				if (out_ch.data.result_den !== want.result_den) begin
					$error("result_den: expected %0d, actual %0d",
						want.result_den, out_ch.data.result_den);
					errors++;
				end
				if (out_ch.data.status !== want.status) begin
					$error("status: expected %0d, actual %0d",
						want.status, out_ch.data.status);
					errors++;
				end
			end
		end
		if (arst_n)
			out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int phase;
		int i;
		logic [2:0] kind;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		arst_n = 1'b0;
		errors = 0;
		results_seen = 0;
		zden_seen = 0;
		ovf_seen = 0;
		ok_seen = 0;
		cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		frac_num = 32'sd0;
		frac_den = 32'sd1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: reset state, field extremes, every operation and the
		// rejection cases.
		foreach (DIRECTED[r])
			send_op(DIRECTED[r].kind, DIRECTED[r].num, DIRECTED[r].den,
				DIRECTED[r].checked_here, DIRECTED[r].want);
		drain_results();

		// Random part in four flow-control phases. Most transactions form
		// a load followed by a short run of arithmetic on small fractions, so
		// the accumulator keeps a nontrivial value; the rest is wide noise.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 25; recv_stall_pct = 25; end
			endcase
			i = 0;
			while (i < RANDOM_ITEMS / 4) begin
				send_op(KIND_LOAD, random_operand(1'b0), random_operand(1'b1), 1'b0, '0);
				i++;
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(0, 15) == 0)
						kind = 3'($urandom_range(5, 7));
					else
						kind = 3'($urandom_range(1, 4));
					send_op(kind, random_operand(1'b1), random_operand(1'b1), 1'b0, '0);
					i++;
				end
			end
			drain_results();
		end

		repeat (50) @(posedge clk);
		$display("Covered %0d results: %0d accepted, %0d zero-denominator, %0d overflow.",
			results_seen, ok_seen, zden_seen, ovf_seen);
		$display("Flow control ran without idling, with sender gaps, receiver stalls and both.");
		if (errors == 0 && pending_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
